// ===== hdl/bitmap_block_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_assert
// Assertion macros for the port-level checks of the block allocator.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Property holds in the same cycle as its trigger.
`define BBA_ASSERT_NOW(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

// Property holds in the cycle after its trigger.
`define BBA_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Types, sizes and codes of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int unsigned MAX_BLOCKS    = 65536;
    localparam int unsigned MAP_WORD_BITS = 64;   // power of two
    localparam int unsigned MAP_DEPTH     = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int unsigned SUM_DEPTH     = (MAP_DEPTH + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

    localparam int unsigned BIT_W  = $clog2(MAP_WORD_BITS);
    localparam int unsigned MAP_AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int unsigned SUM_AW = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
    localparam int unsigned WIDX_W = SUM_AW + BIT_W;
    localparam int unsigned BLK_W  = $clog2(MAX_BLOCKS);

    localparam int unsigned ID_W  = 16;
    localparam int unsigned CFG_W = 17;
    localparam int unsigned ST_W  = 2;

    localparam int unsigned CMP_A = (BLK_W + 1 > CFG_W) ? BLK_W + 1 : CFG_W;
    localparam int unsigned CMP_W = (WIDX_W + BIT_W > CMP_A) ? WIDX_W + BIT_W : CMP_A;

    localparam logic [CFG_W-1:0] CFG_MASK  = 17'h1fff8;
    localparam logic [CFG_W-1:0] CFG_RESET = 17'h10000;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] block_id;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0] block_id_res;
        logic [ST_W-1:0] status;
    } rsp_t;

    // Position of the lowest clear bit (zero when the word is all ones).
    function automatic logic [BIT_W-1:0] first_zero(input logic [MAP_WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== hdl/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit allocator: 1024 x 64 bitmap RAM, 16 x 64 register summary of full words.
// Free: S_FREE, then S_DONE (out of range: S_DONE only). Allocate: S_SCAN over 1..16
// summary words, one per cycle, then S_AREAD and S_DONE, or S_DONE if no word is left.
// One request in flight; the next is taken the cycle after its response is loaded.
// Reset: asynchronous, then a clearing pass of all 1024 RAM words with req_ready low.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  bba_pkg::req_t              req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output bba_pkg::rsp_t              rsp,
    input  logic                       cfg_we,
    input  logic [bba_pkg::CFG_W-1:0]  cfg_wdata
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_AREAD = 6'b001000,
        S_FREE  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [bba_pkg::MAP_AW-1:0]   clr_idx_reg, clr_idx_next;
    logic [bba_pkg::SUM_AW-1:0]   sidx_reg, sidx_next;
    logic [bba_pkg::WIDX_W-1:0]   word_reg, word_next;
    logic [bba_pkg::ID_W-1:0]     id_reg, id_next;
    logic [bba_pkg::ID_W-1:0]     res_id_reg, res_id_next;
    logic [bba_pkg::ST_W-1:0]     res_st_reg, res_st_next;
    bba_pkg::rsp_t                rsp_reg, rsp_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    logic [bba_pkg::CFG_W-1:0]    block_count_reg;

    logic [bba_pkg::MAP_WORD_BITS-1:0] sum_reg [bba_pkg::SUM_DEPTH];
    logic [bba_pkg::MAP_WORD_BITS-1:0] map_mem [bba_pkg::MAP_DEPTH];
    logic [bba_pkg::MAP_WORD_BITS-1:0] map_rd_reg;

    logic                              mem_we, mem_re;
    logic [bba_pkg::MAP_AW-1:0]        mem_waddr, mem_raddr;
    logic [bba_pkg::MAP_WORD_BITS-1:0] mem_wdata;

    logic                              sum_we, sum_val;
    logic [bba_pkg::SUM_AW-1:0]        sum_row;
    logic [bba_pkg::BIT_W-1:0]         sum_bit;

    logic [bba_pkg::CMP_W-1:0]         eff_masked, eff_count, id_cmp;
    logic [bba_pkg::CMP_W-1:0]         scan_base, alloc_blk;
    logic                              req_fire, free_ok, sum_full;
    logic [bba_pkg::MAP_WORD_BITS-1:0] sum_word, set_word, clr_word, one_bit;
    logic [bba_pkg::BIT_W-1:0]         sum_pos, map_pos;
    logic [bba_pkg::WIDX_W-1:0]        scan_word, free_word;

    assign one_bit    = {{(bba_pkg::MAP_WORD_BITS-1){1'b0}}, 1'b1};
    assign eff_masked = bba_pkg::CMP_W'(block_count_reg & bba_pkg::CFG_MASK);
    assign eff_count  = (eff_masked > bba_pkg::CMP_W'(bba_pkg::MAX_BLOCKS))
                        ? bba_pkg::CMP_W'(bba_pkg::MAX_BLOCKS) : eff_masked;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign id_cmp    = bba_pkg::CMP_W'(req.block_id);
    assign free_ok   = id_cmp < eff_count;

    assign sum_word  = sum_reg[sidx_reg];
    assign sum_full  = &sum_word;
    assign sum_pos   = bba_pkg::first_zero(sum_word);
    assign scan_word = {sidx_reg, sum_pos};
    assign scan_base = bba_pkg::CMP_W'(scan_word) << bba_pkg::BIT_W;

    assign map_pos   = bba_pkg::first_zero(map_rd_reg);
    assign alloc_blk = (bba_pkg::CMP_W'(word_reg) << bba_pkg::BIT_W)
                       | bba_pkg::CMP_W'(map_pos);
    assign set_word  = map_rd_reg | (one_bit << map_pos);
    assign clr_word  = map_rd_reg & ~(one_bit << id_reg[bba_pkg::BIT_W-1:0]);
    assign free_word = bba_pkg::WIDX_W'(id_reg >> bba_pkg::BIT_W);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        sidx_next      = sidx_reg;
        word_next      = word_reg;
        id_next        = id_reg;
        res_id_next    = res_id_reg;
        res_st_next    = res_st_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_we         = 1'b0;
        mem_waddr      = clr_idx_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = bba_pkg::MAP_AW'(id_cmp >> bba_pkg::BIT_W);
        sum_we         = 1'b0;
        sum_val        = 1'b0;
        sum_row        = bba_pkg::SUM_AW'(word_reg >> bba_pkg::BIT_W);
        sum_bit        = word_reg[bba_pkg::BIT_W-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == bba_pkg::MAP_AW'(bba_pkg::MAP_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    id_next     = req.block_id;
                    res_id_next = '0;
                    if (req.kind == bba_pkg::KIND_ALLOC)
                    begin
                        sidx_next  = '0;
                        state_next = S_SCAN;
                    end
                    else if (free_ok)
                    begin
                        mem_re     = 1'b1;
                        state_next = S_FREE;
                    end
                    else
                    begin
                        res_st_next = bba_pkg::ST_RANGE;
                        state_next  = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (!sum_full)
                begin
                    // lowest non-full word; past the count means nothing left
                    if (scan_base >= eff_count)
                    begin
                        res_st_next = bba_pkg::ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = bba_pkg::MAP_AW'(scan_word);
                        word_next  = scan_word;
                        state_next = S_AREAD;
                    end
                end
                else if (sidx_reg == bba_pkg::SUM_AW'(bba_pkg::SUM_DEPTH - 1))
                begin
                    res_st_next = bba_pkg::ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    sidx_next = sidx_reg + 1'b1;
                end
            end
            S_AREAD:
            begin
                state_next = S_DONE;
                if (alloc_blk >= eff_count)
                begin
                    res_st_next = bba_pkg::ST_FULL;
                end
                else
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = bba_pkg::MAP_AW'(word_reg);
                    mem_wdata   = set_word;
                    sum_we      = &set_word;
                    sum_val     = 1'b1;
                    res_id_next = alloc_blk[bba_pkg::ID_W-1:0];
                    res_st_next = bba_pkg::ST_OK;
                end
            end
            S_FREE:
            begin
                mem_we      = 1'b1;
                mem_waddr   = bba_pkg::MAP_AW'(free_word);
                mem_wdata   = clr_word;
                sum_we      = 1'b1;
                sum_val     = 1'b0;
                sum_row     = bba_pkg::SUM_AW'(free_word >> bba_pkg::BIT_W);
                sum_bit     = free_word[bba_pkg::BIT_W-1:0];
                res_st_next = bba_pkg::ST_OK;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.block_id_res = res_id_reg;
                    rsp_next.status       = res_st_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            sidx_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
            block_count_reg <= bba_pkg::CFG_RESET;
            for (int i = 0; i < bba_pkg::SUM_DEPTH; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            sidx_reg      <= sidx_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                block_count_reg <= cfg_wdata;
            end
            if (sum_we)
            begin
                sum_reg[sum_row][sum_bit] <= sum_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        id_reg     <= id_next;
        res_id_reg <= res_id_next;
        res_st_reg <= res_st_next;
        rsp_reg    <= rsp_next;
    end

    // bitmap RAM, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            map_rd_reg <= map_mem[mem_raddr];
        end
    end

endmodule

// ===== hdl/bba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_assert.svh"

module bba_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_ready,
    input  logic                       rsp_valid,
    input  logic                       rsp_ready,
    input  bba_pkg::rsp_t              rsp
);

    logic status_known, rsp_failed, fail_id_zero, rsp_stalled, req_fire;

    assign status_known = (rsp.status == bba_pkg::ST_OK) || (rsp.status == bba_pkg::ST_FULL)
                          || (rsp.status == bba_pkg::ST_RANGE);
    assign rsp_failed   = rsp_valid && (rsp.status != bba_pkg::ST_OK);
    assign fail_id_zero = (rsp.block_id_res == '0);
    assign rsp_stalled  = rsp_valid && !rsp_ready;
    assign req_fire     = req_valid && req_ready;

    `BBA_ASSERT_NOW(a_status_code, rsp_valid, status_known, "bad status code")
    `BBA_ASSERT_NOW(a_fail_zero_id, rsp_failed, fail_id_zero, "nonzero block id on failure")
    `BBA_ASSERT_NEXT(a_rsp_hold, rsp_stalled, rsp_valid && $stable(rsp), "response not held")
    `BBA_ASSERT_NEXT(a_one_in_flight, req_fire, !req_ready, "second request taken")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

// ===== verif/bitmap_block_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_tb
// Self-checking bench for the first-fit block allocator. A short table of
// directed requests covers the register extremes, the full map and the
// out-of-range free. Random allocate/free traffic follows under several
// block counts and idle patterns. Every response is checked against a
// bitmap model kept inside the bench, or against the one a directed row gives.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_tb;

    localparam int WATCHDOG_LIMIT  = 5000;  // clearing pass + long hold + margin
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 24;    // longest allocate latency and then some
    localparam int PHASE_COUNT     = 9;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int MAX_GAP         = 40;

    typedef enum logic {ROW_REQ, ROW_CFG} row_op_t;

    typedef struct packed {
        row_op_t                   op;
        logic                      kind;
        logic [bba_pkg::ID_W-1:0]  block_id;
        logic [bba_pkg::CFG_W-1:0] cfg;
        logic                      typed;   // expected response given in the row
        bba_pkg::rsp_t             rsp;
    } step_row_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_ready;
    bba_pkg::req_t             req       = '0;
    logic                      rsp_valid;
    logic                      rsp_ready = 1'b0;
    bba_pkg::rsp_t             rsp;
    logic                      cfg_we    = 1'b0;
    logic [bba_pkg::CFG_W-1:0] cfg_wdata = '0;

    // bitmap model
    logic [bba_pkg::MAP_WORD_BITS-1:0] usage_words [bba_pkg::MAP_DEPTH];
    logic [bba_pkg::CFG_W-1:0]         block_count_setting;

    bba_pkg::rsp_t            pending_rsp_q [$];
    logic [bba_pkg::ID_W-1:0] live_blocks [$];
    bba_pkg::rsp_t            oldest_rsp;

    int errors         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int n_items        = 0;
    int n_allocs       = 0;
    int n_frees        = 0;
    int n_full         = 0;
    int n_range        = 0;
    int n_settings     = 0;

    step_row_t directed_rows [23] = '{
        '{ROW_REQ, bba_pkg::KIND_ALLOC, 16'h0000, 17'h0, 1'b1, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_ALLOC, 16'hffff, 17'h0, 1'b1, '{16'd1, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_FREE,  16'h0000, 17'h0, 1'b1, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_ALLOC, 16'h0000, 17'h0, 1'b1, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_FREE,  16'hffff, 17'h0, 1'b1, '{16'd0, bba_pkg::ST_OK}},
        // freeing a block that is already free
        '{ROW_REQ, bba_pkg::KIND_FREE,  16'hffff, 17'h0, 1'b1, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_ALLOC, 16'h1234, 17'h0, 1'b0, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_CFG, bba_pkg::KIND_ALLOC, 16'h0000, 17'd8, 1'b0, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_ALLOC, 16'h0000, 17'h0, 1'b0, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_ALLOC, 16'h0000, 17'h0, 1'b0, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_ALLOC, 16'h0000, 17'h0, 1'b0, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_ALLOC, 16'h0000, 17'h0, 1'b0, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_ALLOC, 16'h0000, 17'h0, 1'b0, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_ALLOC, 16'h0000, 17'h0, 1'b1, '{16'd0, bba_pkg::ST_FULL}},
        '{ROW_REQ, bba_pkg::KIND_FREE,  16'h0008, 17'h0, 1'b1, '{16'd0, bba_pkg::ST_RANGE}},
        '{ROW_REQ, bba_pkg::KIND_FREE,  16'h0007, 17'h0, 1'b1, '{16'd0, bba_pkg::ST_OK}},
        // count below 8: nothing usable
        '{ROW_CFG, bba_pkg::KIND_ALLOC, 16'h0000, 17'd5, 1'b0, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_ALLOC, 16'h0000, 17'h0, 1'b1, '{16'd0, bba_pkg::ST_FULL}},
        '{ROW_REQ, bba_pkg::KIND_FREE,  16'h0000, 17'h0, 1'b1, '{16'd0, bba_pkg::ST_RANGE}},
        // above the maximum: saturates
        '{ROW_CFG, bba_pkg::KIND_ALLOC, 16'h0000, 17'h1ffff, 1'b0, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_FREE,  16'hffff, 17'h0, 1'b1, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_ALLOC, 16'h0000, 17'h0, 1'b0, '{16'd0, bba_pkg::ST_OK}},
        '{ROW_REQ, bba_pkg::KIND_ALLOC, 16'h0000, 17'h0, 1'b0, '{16'd0, bba_pkg::ST_OK}}
    };

    logic [bba_pkg::CFG_W-1:0] phase_count [PHASE_COUNT] = '{
        17'h10000, 17'd64, 17'd8, 17'd0, 17'd203, 17'd72, 17'h1ffff, 17'd16, 17'd135
    };
    int phase_alloc_pct [PHASE_COUNT] = '{60, 80, 65, 50, 75, 80, 55, 70, 80};
    int mode_send_idle  [4] = '{0, 75, 0, 16};
    int mode_recv_stall [4] = '{0, 0, 75, 16};

    bitmap_block_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned usable_blocks();
        int unsigned c;
        c = 32'(block_count_setting & bba_pkg::CFG_MASK);
        if (c > bba_pkg::MAX_BLOCKS)
        begin
            c = bba_pkg::MAX_BLOCKS;
        end
        return c;
    endfunction

    // Applies one request to the bitmap model and returns its response.
    function automatic bba_pkg::rsp_t allocator_response(input bba_pkg::req_t r);
        bba_pkg::rsp_t res;
        int unsigned   limit;
        int unsigned   base;
        bit            found;
        res.block_id_res = '0;
        res.status       = bba_pkg::ST_OK;
        limit            = usable_blocks();
        found            = 1'b0;
        if (r.kind == bba_pkg::KIND_ALLOC)
        begin
            for (int w = 0; w < bba_pkg::MAP_DEPTH; w++)
            begin
                base = w * bba_pkg::MAP_WORD_BITS;
                if (base >= limit)
                begin
                    break;
                end
                if (&usage_words[w])
                begin
                    continue;
                end
                for (int b = 0; b < bba_pkg::MAP_WORD_BITS; b++)
                begin
                    if (base + b >= limit)
                    begin
                        break;
                    end
                    if (!usage_words[w][b])
                    begin
                        usage_words[w][b] = 1'b1;
                        res.block_id_res  = bba_pkg::ID_W'(base + b);
                        found             = 1'b1;
                        break;
                    end
                end
                // a word with a clear bit ends the scan either way
                break;
            end
            if (!found)
            begin
                res.status = bba_pkg::ST_FULL;
            end
        end
        else if (r.block_id < limit)
        begin
            usage_words[r.block_id[bba_pkg::ID_W-1:bba_pkg::BIT_W]]
                       [r.block_id[bba_pkg::BIT_W-1:0]] = 1'b0;
        end
        else
        begin
            res.status = bba_pkg::ST_RANGE;
        end
        return res;
    endfunction

    // Called right after a rising edge; returns at the edge of the transaction.
    task automatic offer(input bba_pkg::req_t r, input logic typed,
                         input bba_pkg::rsp_t typed_rsp);
        bba_pkg::rsp_t predicted;
        int            gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        predicted = allocator_response(r);
        if (r.kind == bba_pkg::KIND_ALLOC && predicted.status == bba_pkg::ST_OK)
        begin
            live_blocks.push_back(predicted.block_id_res);
        end
        pending_rsp_q.push_back(typed ? typed_rsp : predicted);
        n_items++;
        if (r.kind == bba_pkg::KIND_ALLOC)
        begin
            n_allocs++;
        end
        else
        begin
            n_frees++;
        end
        if (predicted.status == bba_pkg::ST_FULL)
        begin
            n_full++;
        end
        if (predicted.status == bba_pkg::ST_RANGE)
        begin
            n_range++;
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_block_count(input logic [bba_pkg::CFG_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we              <= 1'b0;
        block_count_setting  = value;
        n_settings++;
    endtask

    // response side: random back-pressure plus one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("response transaction with nothing expected: block_id_res %0d status %0d",
                       rsp.block_id_res, rsp.status);
                errors++;
            end
            else
            begin
                oldest_rsp = pending_rsp_q.pop_front();
                if (rsp.block_id_res !== oldest_rsp.block_id_res)
                begin
                    $error("block_id_res: expected %0d, got %0d",
                           oldest_rsp.block_id_res, rsp.block_id_res);
                    errors++;
                end
                if (rsp.status !== oldest_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", oldest_rsp.status, rsp.status);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("bitmap_block_allocator_tb NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        bba_pkg::req_t item;
        int unsigned   pick;
        int unsigned   top;
        int            roll;
        int            mode;

        foreach (usage_words[i])
        begin
            usage_words[i] = '0;
        end
        block_count_setting = bba_pkg::CFG_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_CFG)
            begin
                write_block_count(directed_rows[i].cfg);
            end
            else
            begin
                item.kind     = directed_rows[i].kind;
                item.block_id = directed_rows[i].block_id;
                offer(item, directed_rows[i].typed, directed_rows[i].rsp);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_block_count(phase_count[p]);
            mode           = p % 4;
            send_idle_pct  = mode_send_idle[mode];
            recv_stall_pct = mode_recv_stall[mode];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 0 && n == 30)
                begin
                    hold_request = 1'b1;   // output held off, input backs up
                end
                if (p == 0 && n == 60)
                begin
                    wait_drained();
                end
                item.block_id = bba_pkg::ID_W'($urandom);
                if ($urandom_range(99) < phase_alloc_pct[p])
                begin
                    item.kind = bba_pkg::KIND_ALLOC;
                end
                else
                begin
                    item.kind = bba_pkg::KIND_FREE;
                    roll      = $urandom_range(99);
                    if (roll < 60 && live_blocks.size() > 0)
                    begin
                        pick          = $urandom_range(live_blocks.size() - 1);
                        item.block_id = live_blocks[pick];
                        live_blocks.delete(pick);
                    end
                    else if (roll < 85)
                    begin
                        // near the top of the usable range, both sides of it
                        top           = usable_blocks();
                        item.block_id = bba_pkg::ID_W'($urandom_range(top + 15,
                                                       (top > 16) ? top - 16 : 0));
                    end
                end
                offer(item, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests (%0d allocate, %0d free) over %0d block-count settings",
                 n_items, n_allocs, n_frees, n_settings);
        $display("map-full replies: %0d, out-of-range frees: %0d, mismatches: %0d",
                 n_full, n_range, errors);
        if (errors == 0 && pending_rsp_q.size() == 0)
        begin
            $display("bitmap_block_allocator_tb OK");
        end
        else
        begin
            $display("bitmap_block_allocator_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bba_pkg.sv
hdl/bitmap_block_allocator.sv
hdl/bba_checker.sv
verif/bitmap_block_allocator_tb.sv
